// ===== src/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication, checked on every clock edge out of reset
`define HESD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define HESD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/hesd_pkg.sv =====
// shared constants and types of the haar energy spike detector
package hesd_pkg;
  localparam int MAX_WINDOW_DEF = 256;
  localparam int MAX_LEVELS_DEF = 8;
  localparam int SAMPLE_W = 16;
  localparam int APPROX_W = 24;
  localparam int ENERGY_W = 46;
  localparam int CNT_W = 32;
  localparam int HYST_W = 16;
  localparam int MIN_W = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 46;
  localparam int LEVEL_SLOTS = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_RD_A, ST_RD_B, ST_CALC, ST_MUL, ST_ACC,
    ST_LVL, ST_MAX, ST_THR, ST_DECIDE, ST_OUT
  } state_t;
endpackage

// ===== src/hesd_if.sv =====
// request channels of the haar energy spike detector
interface hesd_cfg_if import hesd_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface hesd_sample_if import hesd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface hesd_result_if import hesd_pkg::*; ();
  logic valid;
  logic ready;
  logic ready_res;
  logic [2:0] level_index;
  logic [ENERGY_W-1:0] level_energy;
  logic last;
  logic spiking_flag;
  logic spike_event;
  logic clear_event;
  logic [2:0] peak_level;
  logic [ENERGY_W-1:0] max_energy;
  logic signed [APPROX_W-1:0] final_approx;
  logic [CNT_W-1:0] spike_count;
  logic [CNT_W-1:0] total_count;
  modport source (output valid, ready_res, level_index, level_energy, last, spiking_flag,
                  spike_event, clear_event, peak_level, max_energy, final_approx,
                  spike_count, total_count, input ready);
  modport sink (input valid, ready_res, level_index, level_energy, last, spiking_flag,
                spike_event, clear_event, peak_level, max_energy, final_approx,
                spike_count, total_count, output ready);
endinterface

// ===== src/haar_energy_spike_detector_top.sv =====
// top level of the haar energy spike detector
// Channels: cfg writes a register by index (always ready; the user must see that it is
// only written while idle, which the block itself does not enforce); samples takes one
// signed sample per request; results gives one result per level (a single result
// with ready_res low while the window is still filling). Each sample goes into a
// ring ram of the last W samples. When enough samples are held, one shared
// add/subtract unit and one 24x24 multiplier walk the window pair by pair over the
// scratch ram, reading both samples of a pair, forming sum and difference, squaring
// the difference and accumulating it; each level is then closed, followed by a peak
// scan over the levels, the threshold decision and one result per level. A sample
// that only fills the window goes from the start state to its single result.
// samples.ready is high only while the block is idle, so a new sample waits until
// the last result of the previous one has been taken; a stalled receiver simply
// holds the current result, whose payload stays stable.
// Reset (rst, synchronous) or any config write to a known register empties the
// ring, the fill count, the spiking flag and both counters; unfilled ring slots
// read as zero, so no clearing pass is needed.
module haar_energy_spike_detector_top import hesd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input logic clk,
  input logic rst,
  hesd_cfg_if.sink cfg,
  hesd_sample_if.sink samples,
  hesd_result_if.source results
);
  localparam int EMAX = $clog2(MAX_WINDOW + 1) - 1;
  localparam int AW = EMAX;
  localparam int DEPTH = 1 << EMAX;
  localparam int SAW = (EMAX > 1) ? EMAX - 1 : 1;
  localparam int SDEPTH = 1 << SAW;
  localparam int FW = EMAX + 1;
  localparam int NW = (FW > MIN_W) ? FW : MIN_W;
  localparam int LMAX_A = (MAX_LEVELS < LEVEL_SLOTS) ? MAX_LEVELS : LEVEL_SLOTS;
  localparam int LMAX = (LMAX_A < EMAX) ? LMAX_A : EMAX;
  localparam int SUM_W = ENERGY_W + EMAX;
  localparam int PROD_W = 2 * APPROX_W - 1;
  localparam int HP_W = ENERGY_W + HYST_W;

  state_t state, state_next;

  logic [3:0] levels, window_log2;
  logic [MIN_W-1:0] fill_min;
  logic [ENERGY_W-1:0] thresh_level;
  logic [HYST_W-1:0] clr_factor;

  logic [AW-1:0] wp;
  logic [FW-1:0] fill;
  logic prev_spiking;
  logic [CNT_W-1:0] spike_cnt, sample_cnt;

  logic [2:0] k;
  logic [SAW-1:0] pi, half_m1;
  logic [SUM_W-1:0] sum;
  logic signed [APPROX_W-1:0] a_q, d_q, approx_last;
  logic [PROD_W-1:0] prod_q;
  logic [ENERGY_W-1:0] energy [LEVEL_SLOTS];
  logic [ENERGY_W-1:0] maxe;
  logic [2:0] peak;
  logic now_q, spk_q, clr_q, nr;
  logic [HP_W-1:0] hprod_q;
  logic zero_q;

  logic [3:0] l_eff, e_eff;
  logic [AW-1:0] wmask;
  logic [FW-1:0] w_full;
  logic [NW-1:0] need;
  logic last_level;

  logic phase;
  logic [SAW:0] off;
  logic [AW-1:0] ring_raddr;
  logic [SAW-1:0] scr_raddr;
  logic [SAMPLE_W-1:0] ring_rdata;
  logic [APPROX_W-1:0] scr_rdata;
  logic scr_we;
  logic signed [APPROX_W-1:0] rd_val;
  logic signed [APPROX_W:0] pair_sum, pair_diff;
  logic signed [APPROX_W-1:0] approx_new;
  logic accept, cfg_hit;

  always_comb begin
    l_eff = levels;
    if (l_eff < 4'd1) l_eff = 4'd1;
    if (l_eff > 4'(LMAX)) l_eff = 4'(LMAX);
    e_eff = window_log2;
    if (e_eff < l_eff) e_eff = l_eff;
    if (e_eff > 4'(EMAX)) e_eff = 4'(EMAX);
    wmask = (AW'(1) << e_eff) - AW'(1);
    w_full = FW'(1) << e_eff;
    need = (fill_min == '0) ? NW'(w_full) : NW'(fill_min);
    last_level = ({1'b0, k} == l_eff - 4'd1);
  end

  assign accept = samples.valid && samples.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg.valid) begin
      case (cfg.index)
        REG_LEVELS, REG_WINDOW_LOG2, REG_MIN_SAMPLES, REG_THRESHOLD,
        REG_HYSTERESIS: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_START;
      ST_START: state_next = (NW'(fill) < need) ? ST_OUT : ST_RD_A;
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_CALC;
      ST_CALC: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (pi == half_m1) ? ST_LVL : ST_RD_A;
      ST_LVL: state_next = last_level ? ST_MAX : ST_RD_A;
      ST_MAX: state_next = last_level ? ST_THR : ST_MAX;
      ST_THR: state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT: if (results.ready && (nr || last_level)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    samples.ready = (state == ST_IDLE);
    results.valid = (state == ST_OUT);
    phase = (state == ST_RD_B);
    scr_we = (state == ST_CALC);
  end

  assign off = {pi, phase};
  assign ring_raddr = (wp + AW'(off)) & wmask;
  assign scr_raddr = SAW'(off);

  always_comb begin
    if (k == 3'd0) begin
      rd_val = zero_q ? '0 : $signed({ring_rdata, 8'd0});
    end else begin
      rd_val = $signed(scr_rdata);
    end
    pair_sum = {a_q[APPROX_W-1], a_q} + {rd_val[APPROX_W-1], rd_val};
    pair_diff = {a_q[APPROX_W-1], a_q} - {rd_val[APPROX_W-1], rd_val};
    approx_new = APPROX_W'(pair_sum >>> 1);
  end

  hesd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ring (
    .clk(clk), .we(accept), .waddr(wp), .wdata(samples.sample),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  hesd_ram #(.WIDTH(APPROX_W), .DEPTH(SDEPTH)) u_scratch (
    .clk(clk), .we(scr_we), .waddr(pi), .wdata(approx_new),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      levels <= 4'd4;
      window_log2 <= 4'd8;
      fill_min <= '0;
      thresh_level <= '0;
      clr_factor <= HYST_W'(3277);
      wp <= '0;
      fill <= '0;
      prev_spiking <= 1'b0;
      spike_cnt <= '0;
      sample_cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          REG_LEVELS: levels <= cfg.data[3:0];
          REG_WINDOW_LOG2: window_log2 <= cfg.data[3:0];
          REG_MIN_SAMPLES: fill_min <= cfg.data[MIN_W-1:0];
          REG_THRESHOLD: thresh_level <= cfg.data[ENERGY_W-1:0];
          REG_HYSTERESIS: clr_factor <= cfg.data[HYST_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        wp <= '0;
        fill <= '0;
        prev_spiking <= 1'b0;
        spike_cnt <= '0;
        sample_cnt <= '0;
      end else begin
        if (accept) begin
          sample_cnt <= sample_cnt + CNT_W'(1);
          wp <= (wp + AW'(1)) & wmask;
          fill <= (fill < w_full) ? fill + FW'(1) : w_full;
        end
        if (state == ST_DECIDE) begin
          prev_spiking <= now_q;
          if (now_q && !prev_spiking) spike_cnt <= spike_cnt + CNT_W'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    zero_q <= ({1'b0, ring_raddr} >= fill);
    case (state)
      ST_START: begin
        nr <= (NW'(fill) < need);
        k <= '0;
        pi <= '0;
        sum <= '0;
        half_m1 <= SAW'((w_full >> 1) - FW'(1));
      end
      ST_RD_B: a_q <= rd_val;
      ST_CALC: begin
        d_q <= APPROX_W'(pair_diff >>> 1);
        if (pi == '0) approx_last <= approx_new;
      end
      ST_MUL: prod_q <= PROD_W'(d_q * d_q);
      ST_ACC: begin
        sum <= sum + SUM_W'(prod_q);
        if (pi != half_m1) pi <= pi + SAW'(1);
      end
      ST_LVL: begin
        energy[k] <= ENERGY_W'(sum >> (e_eff - {1'b0, k} - 4'd1));
        pi <= '0;
        sum <= '0;
        half_m1 <= half_m1 >> 1;
        maxe <= '0;
        peak <= '0;
        k <= last_level ? 3'd0 : k + 3'd1;
      end
      ST_MAX: begin
        if (energy[k] > maxe) begin
          maxe <= energy[k];
          peak <= k;
        end
        if (!last_level) k <= k + 3'd1;
      end
      ST_THR: begin
        now_q <= (maxe > thresh_level);
        hprod_q <= HP_W'(thresh_level) * HP_W'(clr_factor);
      end
      ST_DECIDE: begin
        spk_q <= now_q && !prev_spiking;
        clr_q <= !now_q && prev_spiking && ({maxe, 12'd0} < hprod_q);
        nr <= 1'b0;
        k <= '0;
      end
      ST_OUT: if (results.ready && !last_level) k <= k + 3'd1;
      default: ;
    endcase
  end

  always_comb begin
    results.ready_res = !nr;
    results.level_index = nr ? 3'd0 : k;
    results.level_energy = nr ? '0 : energy[k];
    results.last = nr || last_level;
    results.spiking_flag = prev_spiking;
    results.spike_event = !nr && spk_q;
    results.clear_event = !nr && clr_q;
    results.peak_level = (!nr && spk_q) ? peak : 3'd0;
    results.max_energy = nr ? '0 : maxe;
    results.final_approx = nr ? '0 : approx_last;
    results.spike_count = spike_cnt;
    results.total_count = sample_cnt;
  end
endmodule

// ===== src/hesd_ram.sv =====
// generic simple dual-port ram with registered read
module hesd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/hesd_checker.sv =====
// port-level checker of the haar energy spike detector and its bind
`include "assert_macros.svh"
module hesd_checker import hesd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic s_valid,
  input logic s_ready,
  input logic r_valid,
  input logic r_ready,
  input logic r_last,
  input logic r_ready_res,
  input logic [ENERGY_W-1:0] r_energy
);
  `HESD_CHECK(no_take_while_result, s_ready, !r_valid, "sample taken while a result waits")
  `HESD_CHECK_NEXT(busy_after_take, s_valid && s_ready, !s_ready, "ready right after a sample")
  `HESD_CHECK_NEXT(idle_after_last, r_valid && r_ready && r_last, !r_valid, "result after last")
  `HESD_CHECK(fill_single, r_valid && !r_ready_res, r_last, "filling result not last")
  `HESD_CHECK_NEXT(hold_stall, r_valid && !r_ready, r_valid && $stable(r_energy),
                   "stalled result changed")
endmodule

bind haar_energy_spike_detector_top hesd_checker u_hesd_checker (
  .clk(clk), .rst(rst),
  .s_valid(samples.valid), .s_ready(samples.ready),
  .r_valid(results.valid), .r_ready(results.ready),
  .r_last(results.last), .r_ready_res(results.ready_res),
  .r_energy(results.level_energy)
);
